// ----- rtl/btfp_pkg.sv -----
// Shared types, character codes and constants of the bracket telemetry frame parser.
`default_nettype none

package btfp_pkg;

    localparam int MAG_W = 32;
    localparam int BYTE_W = 8;
    localparam int POS_W = 2;
    localparam int FRACTION_DIGITS_DEF = 3;

    // Largest magnitude kept while scanning; a negative reading may reach it.
    localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [MAG_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C;  // <
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E;  // >
    localparam logic [BYTE_W-1:0] CH_S     = 8'h73;  // s
    localparam logic [BYTE_W-1:0] CH_V     = 8'h76;  // v
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Body position where the number starts.
    localparam logic [POS_W-1:0] POS_VOLT_START   = 2'd2;
    localparam logic [POS_W-1:0] POS_SENSOR_START = 2'd3;

    localparam logic [1:0] CHAN_S1   = 2'd0;
    localparam logic [1:0] CHAN_S2   = 2'd1;
    localparam logic [1:0] CHAN_VOLT = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_S1   = 2'd1,
        KIND_S2   = 2'd2,
        KIND_VOLT = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_LEAD = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    // Snapshot of a frame at its closing bracket.
    typedef struct packed {
        logic             hit;
        t_kind            kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             ovf;
    } t_frame_end;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        case (n)
            0:       p = 32'd1;
            1:       p = 32'd10;
            2:       p = 32'd100;
            3:       p = 32'd1000;
            4:       p = 32'd10000;
            5:       p = 32'd100000;
            6:       p = 32'd1000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/btfp_scan.sv -----
// Frame tracker and number scanner: one received byte per beat.
`default_nettype none

module btfp_scan #(
    parameter int FRACTION_DIGITS = btfp_pkg::FRACTION_DIGITS_DEF,
    parameter int FC_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [btfp_pkg::BYTE_W-1:0]  i_byte,
    output btfp_pkg::t_frame_end              o_end,
    output logic [FC_W-1:0]                   o_pad
);

    localparam int ACC_W = btfp_pkg::MAG_W + 4;

    logic                          r_inside, n_inside;
    logic [btfp_pkg::POS_W-1:0]    r_pos, n_pos;
    btfp_pkg::t_kind               r_kind, n_kind;
    btfp_pkg::t_phase              r_phase, n_phase;
    logic                          r_neg, n_neg;
    logic [FC_W-1:0]               r_fc, n_fc;
    logic [btfp_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic                          r_ovf, n_ovf;

    logic                          is_digit;
    logic                          is_space;
    logic                          sensor;
    logic [btfp_pkg::POS_W-1:0]    start;
    logic [ACC_W-1:0]              acc;
    logic [btfp_pkg::MAG_W-1:0]    acc_mag;
    logic                          acc_ovf;
    logic                          take_int;

    always_comb begin
        is_digit = (i_byte >= btfp_pkg::CH_ZERO) && (i_byte <= btfp_pkg::CH_NINE);
        is_space = (i_byte == btfp_pkg::CH_SPACE) ||
                   ((i_byte >= btfp_pkg::CH_TAB) && (i_byte <= btfp_pkg::CH_CR));
        sensor   = (r_kind != btfp_pkg::KIND_VOLT);
        start    = sensor ? btfp_pkg::POS_SENSOR_START : btfp_pkg::POS_VOLT_START;

        // mag * 10 + digit, clamped at the magnitude limit
        acc = (ACC_W'(r_mag) << 3) + (ACC_W'(r_mag) << 1) + ACC_W'(i_byte[3:0]);
        if (acc > ACC_W'(btfp_pkg::MAG_LIMIT)) begin
            acc_mag = btfp_pkg::MAG_LIMIT;
            acc_ovf = 1'b1;
        end else begin
            acc_mag = acc[btfp_pkg::MAG_W-1:0];
            acc_ovf = r_ovf;
        end
    end

    always_comb begin
        n_inside = r_inside;
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_fc     = r_fc;
        n_mag    = r_mag;
        n_ovf    = r_ovf;
        take_int = 1'b0;

        if (!r_inside || (i_byte == btfp_pkg::CH_CLOSE)) begin
            // Outside a frame, or at its end: an opening '<' or the closing '>' clears the frame state.
            if (!r_inside) begin
                n_inside = (i_byte == btfp_pkg::CH_OPEN);
            end else begin
                n_inside = 1'b0;
            end
            if (!r_inside && (i_byte != btfp_pkg::CH_OPEN)) begin
                n_inside = 1'b0;
            end else begin
                n_pos   = '0;
                n_kind  = btfp_pkg::KIND_NONE;
                n_phase = btfp_pkg::PH_LEAD;
                n_neg   = 1'b0;
                n_fc    = '0;
                n_mag   = '0;
                n_ovf   = 1'b0;
            end
        end else if (r_pos == '0) begin
            n_kind = (i_byte == btfp_pkg::CH_S) ? btfp_pkg::KIND_S1 :
                     (i_byte == btfp_pkg::CH_V) ? btfp_pkg::KIND_VOLT : btfp_pkg::KIND_NONE;
            n_pos  = btfp_pkg::POS_W'(1);
        end else if (r_kind == btfp_pkg::KIND_NONE) begin
            n_pos = r_pos;
        end else if ((r_pos == btfp_pkg::POS_W'(1)) && (r_kind == btfp_pkg::KIND_S1)) begin
            n_kind = (i_byte == btfp_pkg::CH_ONE) ? btfp_pkg::KIND_S1 :
                     (i_byte == btfp_pkg::CH_TWO) ? btfp_pkg::KIND_S2 : btfp_pkg::KIND_NONE;
            n_pos  = btfp_pkg::POS_W'(2);
        end else if (r_pos < start) begin
            n_pos = r_pos + btfp_pkg::POS_W'(1);
        end else begin
            unique case (r_phase)
                btfp_pkg::PH_LEAD: begin
                    if (is_space) begin
                        n_phase = r_phase;
                    end else if ((i_byte == btfp_pkg::CH_PLUS) ||
                                 (i_byte == btfp_pkg::CH_MINUS)) begin
                        n_neg   = (i_byte == btfp_pkg::CH_MINUS);
                        n_phase = btfp_pkg::PH_INT;
                    end else begin
                        take_int = 1'b1;
                    end
                end
                btfp_pkg::PH_INT: begin
                    take_int = 1'b1;
                end
                btfp_pkg::PH_FRAC: begin
                    if (is_digit) begin
                        if (r_fc < FC_W'(FRACTION_DIGITS)) begin
                            n_mag = acc_mag;
                            n_ovf = acc_ovf;
                            n_fc  = r_fc + FC_W'(1);
                        end
                    end else begin
                        n_phase = btfp_pkg::PH_DONE;
                    end
                end
                btfp_pkg::PH_DONE: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = btfp_pkg::PH_DONE;
                end
            endcase
            if (take_int) begin
                if (is_digit) begin
                    n_mag   = acc_mag;
                    n_ovf   = acc_ovf;
                    n_phase = btfp_pkg::PH_INT;
                end else if (sensor && (i_byte == btfp_pkg::CH_POINT)) begin
                    n_phase = btfp_pkg::PH_FRAC;
                end else begin
                    n_phase = btfp_pkg::PH_DONE;
                end
            end
        end
    end

    // A lone 's' keeps the provisional sensor-one kind at position one: no result.
    always_comb begin
        o_end.hit  = r_inside && (i_byte == btfp_pkg::CH_CLOSE) &&
                     (r_kind != btfp_pkg::KIND_NONE) &&
                     !(sensor && (r_pos < btfp_pkg::POS_W'(2)));
        o_end.kind = r_kind;
        o_end.neg  = r_neg;
        o_end.mag  = r_mag;
        o_end.ovf  = r_ovf;
        o_pad      = sensor ? (FC_W'(FRACTION_DIGITS) - r_fc) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pos    <= '0;
            r_kind   <= btfp_pkg::KIND_NONE;
            r_phase  <= btfp_pkg::PH_LEAD;
            r_neg    <= 1'b0;
            r_fc     <= '0;
            r_mag    <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_fc     <= n_fc;
            r_mag    <= n_mag;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/btfp_finish.sv -----
// Fraction padding, 32-bit saturation and the result register.
`default_nettype none

module btfp_finish #(
    parameter int FRACTION_DIGITS = btfp_pkg::FRACTION_DIGITS_DEF,
    parameter int FC_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic                  i_drain,
    input  btfp_pkg::t_frame_end       i_end,
    input  wire logic [FC_W-1:0]       i_pad,
    output logic                       o_valid,
    output logic [1:0]                 o_channel,
    output logic signed [31:0]         o_reading,
    output logic                       o_clipped
);

    localparam int SCALE_W = $clog2(btfp_pkg::pow10(FRACTION_DIGITS) + 1);
    localparam int P_W     = btfp_pkg::MAG_W + SCALE_W;

    logic [SCALE_W-1:0]          scale;
    logic [P_W-1:0]              prod;
    logic [btfp_pkg::MAG_W-1:0]  mag_s;
    logic                        clip;
    logic [1:0]                  chan;

    logic                        r_valid;
    logic [1:0]                  r_channel;
    logic signed [31:0]          r_reading;
    logic                        r_clipped;

    always_comb begin
        // Padding missing fraction digits with zeros is one scale by 10^pad.
        scale = SCALE_W'(btfp_pkg::pow10(int'(i_pad)));
        prod  = P_W'(i_end.mag) * P_W'(scale);
        clip  = i_end.ovf;
        if (prod > P_W'(btfp_pkg::MAG_LIMIT)) begin
            mag_s = btfp_pkg::MAG_LIMIT;
            clip  = 1'b1;
        end else begin
            mag_s = prod[btfp_pkg::MAG_W-1:0];
        end
        if (!i_end.neg && (mag_s > btfp_pkg::POS_MAX)) begin
            mag_s = btfp_pkg::POS_MAX;
            clip  = 1'b1;
        end
        unique case (i_end.kind)
            btfp_pkg::KIND_S1:   chan = btfp_pkg::CHAN_S1;
            btfp_pkg::KIND_S2:   chan = btfp_pkg::CHAN_S2;
            btfp_pkg::KIND_VOLT: chan = btfp_pkg::CHAN_VOLT;
            default:             chan = btfp_pkg::CHAN_S1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_end.hit;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_end.hit) begin
            r_channel <= chan;
            r_reading <= i_end.neg ? $signed(-mag_s) : $signed(mag_s);
            r_clipped <= clip;
        end
    end

    assign o_valid   = r_valid;
    assign o_channel = r_channel;
    assign o_reading = r_reading;
    assign o_clipped = r_clipped;

endmodule

`default_nettype wire

// ----- rtl/bracket_telemetry_frame_parser.sv -----
// Bracket telemetry frame parser: one received byte per beat in, decoded
// readings out. Frames <s1_N>, <s2_N> and <v_N> each give one result at the
// closing '>' (sensor readings in units of 10^-FRACTION_DIGITS, voltage as a
// plain integer, saturated to 32 bits with o_clipped set); other bytes give
// nothing. A byte is taken every cycle while o_in_stall is low; the result of
// a closing '>' appears on the output register the cycle after that byte is
// accepted. The single output register sets the throughput under back-pressure:
// o_in_stall follows i_out_stall combinationally while a result is held.
`default_nettype none

module bracket_telemetry_frame_parser #(
    parameter int FRACTION_DIGITS = btfp_pkg::FRACTION_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [btfp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_channel,
    output logic signed [31:0]                o_reading,
    output logic                              o_clipped
);

    localparam int FC_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;

    logic                  accept;
    btfp_pkg::t_frame_end  frame_end;
    logic [FC_W-1:0]       pad;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    btfp_scan #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .FC_W            (FC_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .o_end    (frame_end),
        .o_pad    (pad)
    );

    btfp_finish #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .FC_W            (FC_W)
    ) u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_drain   (!i_out_stall),
        .i_end     (frame_end),
        .i_pad     (pad),
        .o_valid   (o_out_valid),
        .o_channel (o_channel),
        .o_reading (o_reading),
        .o_clipped (o_clipped)
    );

endmodule

`default_nettype wire
